/* rtl/kwdpp_pkg.sv */
// ----------------------------------------------------------------------------
// kwdpp_pkg
// Shared types and constants for the keyword detection post-processor.
// ----------------------------------------------------------------------------
package kwdpp_pkg;

   localparam int MAX_CLASSES_DEF = 16;
   localparam int SCORE_BITS      = 16;
   localparam int CFG_W           = 16;
   localparam int CFG_IDX_W       = 2;
   localparam int CLASS_W         = 4;
   localparam int TIME_W          = 32;
   localparam int COUNT_W         = 16;

   // item actions
   localparam logic [1:0] ACT_SCORE    = 2'd0;
   localparam logic [1:0] ACT_FINALIZE = 2'd1;
   localparam logic [1:0] ACT_READ     = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_FRAME    = 2'd0;
   localparam logic [1:0] KIND_FINALIZE = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_CLASSES_IN_USE = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_SILENCE_CLASS  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SILENCE_FRAMES = 2'd2;

   // register reset values
   localparam logic [4:0]         RST_CLASSES_IN_USE = 5'd16;
   localparam logic [CLASS_W-1:0] RST_SILENCE_CLASS  = 4'd0;
   localparam logic [COUNT_W-1:0] RST_SILENCE_FRAMES = 16'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [SCORE_BITS-1:0] score;
      logic [TIME_W-1:0]            frame_start;
      logic [TIME_W-1:0]            frame_end;
      logic [CLASS_W-1:0]           read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]                   kind;
      logic                         detected;
      logic [CLASS_W-1:0]           kept_keyword;
      logic [TIME_W-1:0]            kept_begin;
      logic [TIME_W-1:0]            kept_finish;
      logic signed [SCORE_BITS-1:0] read_score;
   } rsp_type;

endpackage

/* rtl/kwdpp_bank_ram.sv */
// ----------------------------------------------------------------------------
// kwdpp_bank_ram
// Score bank storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kwdpp_bank_ram #(
   parameter int DEPTH = 2 * kwdpp_pkg::MAX_CLASSES_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [kwdpp_pkg::SCORE_BITS-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [kwdpp_pkg::SCORE_BITS-1:0] rd_data
);

   logic signed [kwdpp_pkg::SCORE_BITS-1:0] mem [DEPTH];
   logic signed [kwdpp_pkg::SCORE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/keyword_detection_postprocessor.sv */
// ----------------------------------------------------------------------------
// keyword_detection_postprocessor
// Per-frame argmax over class scores, silence run tracking and kept keyword
// with two score banks held in one RAM.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  --------+--------------------------------+---------------------------------
//  request | req_valid / req_ready / req_data | one class score or action
//  result  | rsp_valid / rsp_ready / rsp_data | frame, finalize or read item
//  config  | csr_we / csr_index / csr_wdata  | register write, no wait
//
//  One request item per cycle while req_ready is high. Frame, finalize and
//  read results pass through the read stage, which registers the bank RAM
//  read, and then the output register. Argmax and keep decision are done at
//  acceptance; the kept class score sits in a register, so no RAM read is
//  on the decision path. A stalled output holds the stage behind it, which
//  then drops req_ready. Synchronous reset; the bank RAM is not cleared.
// ----------------------------------------------------------------------------
module keyword_detection_postprocessor #(
   parameter int MAX_CLASSES = kwdpp_pkg::MAX_CLASSES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kwdpp_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kwdpp_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [kwdpp_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [kwdpp_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_CLASSES);
   localparam int LEN_W  = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
   localparam int CMP_W  = (IDX_W > kwdpp_pkg::CLASS_W) ? IDX_W : kwdpp_pkg::CLASS_W;
   // bank select is the top address bit, so each bank spans a power of two
   localparam int DEPTH  = 2 * (2 ** IDX_W);
   localparam int ADDR_W = $clog2(DEPTH);

   // configuration
   logic [4:0]                          classes_in_use_ff;
   logic [kwdpp_pkg::CLASS_W-1:0]       silence_class_ff;
   logic [kwdpp_pkg::COUNT_W-1:0]       silence_frames_ff;

   // tracking state
   logic [IDX_W-1:0]                    elem_idx_ff, elem_idx_in;
   logic                                bank_sel_ff, bank_sel_in;
   logic [IDX_W-1:0]                    best_idx_ff, best_idx_in;
   logic signed [kwdpp_pkg::SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [kwdpp_pkg::CLASS_W-1:0]       kept_class_ff, kept_class_in;
   logic [kwdpp_pkg::TIME_W-1:0]        kept_begin_ff, kept_begin_in;
   logic [kwdpp_pkg::TIME_W-1:0]        kept_finish_ff, kept_finish_in;
   logic signed [kwdpp_pkg::SCORE_BITS-1:0] kept_score_ff, kept_score_in;
   logic [kwdpp_pkg::COUNT_W-1:0]       silence_count_ff, silence_count_in;

   // read stage and output register
   logic                                s1_valid_ff;
   kwdpp_pkg::rsp_type                  s1_data_ff, s1_data_in;
   logic                                s1_use_mem_ff, s1_use_mem_in;
   logic                                rsp_valid_ff;
   kwdpp_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                                accept, s1_move, has_result;
   logic                                take_new, is_last, win_silent, replace;
   logic [IDX_W-1:0]                    cur_idx;
   logic signed [kwdpp_pkg::SCORE_BITS-1:0] cur_score;
   logic [LEN_W-1:0]                    frame_len;
   logic [CMP_W-1:0]                    cur_idx_ext;
   logic [CMP_W-1:0]                    ri_ext;
   logic                                ri_ok;

   logic                                ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                   ram_wr_addr, ram_rd_addr;
   logic signed [kwdpp_pkg::SCORE_BITS-1:0] ram_rd_data;

   assign s1_move   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_move;
   assign accept    = req_valid & req_ready;

   always_comb begin
      if (classes_in_use_ff == '0) begin
         frame_len = LEN_W'(1);
      end else if (LEN_W'(classes_in_use_ff) > LEN_W'(MAX_CLASSES)) begin
         frame_len = LEN_W'(MAX_CLASSES);
      end else begin
         frame_len = LEN_W'(classes_in_use_ff);
      end
   end

   // running argmax, lowest index wins ties
   assign take_new   = (elem_idx_ff == '0) || (best_score_ff < req_data.score);
   assign cur_idx    = take_new ? elem_idx_ff : best_idx_ff;
   assign cur_score  = take_new ? req_data.score : best_score_ff;
   assign is_last    = (LEN_W'(elem_idx_ff) + LEN_W'(1)) >= frame_len;
   assign cur_idx_ext = CMP_W'(cur_idx);
   assign win_silent = cur_idx_ext == CMP_W'(silence_class_ff);
   assign replace    = ~win_silent &&
                       ((silence_count_ff >= silence_frames_ff) ||
                        (kept_score_ff < cur_score));

   assign ri_ext = CMP_W'(req_data.read_index);
   assign ri_ok  = 32'(ri_ext) < 32'(MAX_CLASSES);

   always_comb begin
      elem_idx_in      = elem_idx_ff;
      bank_sel_in      = bank_sel_ff;
      best_idx_in      = best_idx_ff;
      best_score_in    = best_score_ff;
      kept_class_in    = kept_class_ff;
      kept_begin_in    = kept_begin_ff;
      kept_finish_in   = kept_finish_ff;
      kept_score_in    = kept_score_ff;
      silence_count_in = silence_count_ff;
      has_result       = 1'b0;
      s1_use_mem_in    = 1'b0;
      s1_data_in       = '0;

      case (req_data.action)
         kwdpp_pkg::ACT_SCORE: begin
            best_idx_in   = cur_idx;
            best_score_in = cur_score;
            if (!is_last) begin
               elem_idx_in = elem_idx_ff + IDX_W'(1);
            end else begin
               elem_idx_in = '0;
               has_result  = 1'b1;
               if (win_silent) begin
                  if (silence_count_ff < kwdpp_pkg::COUNT_MAX) begin
                     silence_count_in = silence_count_ff + kwdpp_pkg::COUNT_W'(1);
                  end
               end else begin
                  if (replace) begin
                     kept_class_in  = cur_idx_ext[kwdpp_pkg::CLASS_W-1:0];
                     kept_begin_in  = req_data.frame_start;
                     kept_finish_in = req_data.frame_end;
                     kept_score_in  = cur_score;
                     bank_sel_in    = ~bank_sel_ff;
                  end
                  silence_count_in = '0;
               end
               s1_data_in.kind     = kwdpp_pkg::KIND_FRAME;
               s1_data_in.detected = (silence_count_in == silence_frames_ff) &&
                                     (kept_class_in != silence_class_ff);
            end
         end
         kwdpp_pkg::ACT_FINALIZE: begin
            has_result = 1'b1;
            s1_data_in.kind = kwdpp_pkg::KIND_FINALIZE;
            if (silence_count_ff < silence_frames_ff) begin
               silence_count_in    = silence_frames_ff;
               s1_data_in.detected = 1'b1;
            end
         end
         kwdpp_pkg::ACT_READ: begin
            has_result      = 1'b1;
            s1_use_mem_in   = ri_ok;
            s1_data_in.kind = kwdpp_pkg::KIND_READ;
         end
         default: begin
         end
      endcase

      s1_data_in.kept_keyword = kept_class_in;
      s1_data_in.kept_begin   = kept_begin_in;
      s1_data_in.kept_finish  = kept_finish_in;
   end

   // frame scores go to the idle bank, reads come from the kept bank
   assign ram_wr_en   = accept && (req_data.action == kwdpp_pkg::ACT_SCORE);
   assign ram_wr_addr = {~bank_sel_ff, elem_idx_ff};
   assign ram_rd_en   = accept && (req_data.action == kwdpp_pkg::ACT_READ) && ri_ok;
   assign ram_rd_addr = {bank_sel_ff, ri_ext[IDX_W-1:0]};

   kwdpp_bank_ram #(
      .DEPTH(DEPTH)
   ) u_bank_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_data.score),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         classes_in_use_ff <= kwdpp_pkg::RST_CLASSES_IN_USE;
         silence_class_ff  <= kwdpp_pkg::RST_SILENCE_CLASS;
         silence_frames_ff <= kwdpp_pkg::RST_SILENCE_FRAMES;
         elem_idx_ff       <= '0;
         bank_sel_ff       <= 1'b0;
         best_idx_ff       <= '0;
         best_score_ff     <= '0;
         kept_class_ff     <= kwdpp_pkg::RST_SILENCE_CLASS;
         kept_begin_ff     <= '0;
         kept_finish_ff    <= '0;
         silence_count_ff  <= kwdpp_pkg::RST_SILENCE_FRAMES;
      end else if (csr_we) begin
         if (csr_index inside {kwdpp_pkg::REG_CLASSES_IN_USE,
                               kwdpp_pkg::REG_SILENCE_CLASS,
                               kwdpp_pkg::REG_SILENCE_FRAMES}) begin
            elem_idx_ff   <= '0;
            best_idx_ff   <= '0;
            best_score_ff <= '0;
         end
         // kept class and silence run restart from the new settings
         case (csr_index)
            kwdpp_pkg::REG_CLASSES_IN_USE: begin
               classes_in_use_ff <= csr_wdata[4:0];
               kept_class_ff     <= silence_class_ff;
               silence_count_ff  <= silence_frames_ff;
            end
            kwdpp_pkg::REG_SILENCE_CLASS: begin
               silence_class_ff <= csr_wdata[kwdpp_pkg::CLASS_W-1:0];
               kept_class_ff    <= csr_wdata[kwdpp_pkg::CLASS_W-1:0];
               silence_count_ff <= silence_frames_ff;
            end
            kwdpp_pkg::REG_SILENCE_FRAMES: begin
               silence_frames_ff <= csr_wdata;
               kept_class_ff     <= silence_class_ff;
               silence_count_ff  <= csr_wdata;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         elem_idx_ff      <= elem_idx_in;
         bank_sel_ff      <= bank_sel_in;
         best_idx_ff      <= best_idx_in;
         best_score_ff    <= best_score_in;
         kept_class_ff    <= kept_class_in;
         kept_begin_ff    <= kept_begin_in;
         kept_finish_ff   <= kept_finish_in;
         silence_count_ff <= silence_count_in;
      end
   end

   // kept class score; only compared after a replacement has loaded it
   always_ff @(posedge clock) begin
      if (accept) begin
         kept_score_ff <= kept_score_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && has_result) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in            = s1_data_ff;
      rsp_data_in.read_score = s1_use_mem_ff ? ram_rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         s1_data_ff    <= s1_data_in;
         s1_use_mem_ff <= s1_use_mem_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/kwdpp_checker.sv */
// ----------------------------------------------------------------------------
// kwdpp_checker
// Port-level checks for the keyword detection post-processor.
// ----------------------------------------------------------------------------
module kwdpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input kwdpp_pkg::rsp_type rsp_data
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_read_no_detect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == kwdpp_pkg::KIND_READ |-> !rsp_data.detected)
      else $error("read item flags a detection");

   a_verdict_no_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != kwdpp_pkg::KIND_READ |-> rsp_data.read_score == '0)
      else $error("verdict item carries read data");

endmodule

bind keyword_detection_postprocessor kwdpp_checker u_kwdpp_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
